// File: sv/dirty_tile_mask_marker_assert.svh
// ----------------------------------------------------------------------------
// Dirty tile mask marker: assertion macros
// Clocked on clk_i and disabled while rst_ni is low in the including module.
// ----------------------------------------------------------------------------
`ifndef DIRTY_TILE_MASK_MARKER_ASSERT_SVH
`define DIRTY_TILE_MASK_MARKER_ASSERT_SVH

// Same-cycle implication
`define DTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtm: same-cycle check failed");

// Next-cycle implication
`define DTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtm: next-cycle check failed");

`endif

// File: sv/dtm_pkg.sv
// ----------------------------------------------------------------------------
// Dirty tile mask marker package
// Command codes, fixed widths and the job record passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

  localparam int MASK_BITS   = 36;
  localparam int COORD_W     = 12;  // input coordinates
  localparam int BOX_W       = 14;  // padded box corners
  localparam int DELTA_W     = 13;  // line deltas
  localparam int ERR_W       = 15;  // Bresenham error term
  localparam int PAD_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_RECT  = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [BOX_W-1:0] xa;
    logic signed [BOX_W-1:0] ya;
    logic signed [BOX_W-1:0] xb;
    logic signed [BOX_W-1:0] yb;
  } box_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [DELTA_W-1:0] dx;   // |x1 - x0|
    logic signed [DELTA_W-1:0] dy;   // -|y1 - y0|
    logic                      x_dec;
    logic                      y_dec;
    logic signed [ERR_W-1:0]   err;
    logic [PAD_W-1:0]          pad;
  } line_t;

  typedef struct packed {
    kind_e kind;
    logic  mark;   // box kinds: marks tiles (empty rectangles do not)
    box_t  box;
    line_t line;
  } job_t;

endpackage

`default_nettype wire

// File: sv/dtm_if.sv
// ----------------------------------------------------------------------------
// Dirty tile mask marker channels
// Command and mask streams, valid/ready, one item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtm_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [11:0] start_x;
  logic signed [11:0] start_y;
  logic signed [11:0] end_x;
  logic signed [11:0] end_y;
  logic signed [11:0] width;
  logic signed [11:0] height;
  logic [7:0]        padding;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, width, height,
                  padding, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, width, height,
                  padding, output ready);
endinterface

interface dtm_mask_if;
  logic        valid;
  logic        ready;
  logic [35:0] dirty_mask;

  modport source (output valid, dirty_mask, input ready);
  modport sink   (input valid, dirty_mask, output ready);
endinterface

`default_nettype wire

// File: sv/dtm_front.sv
// ----------------------------------------------------------------------------
// Dirty tile mask marker front end
// Takes command beats and turns them into jobs: padded boxes for points and
// rectangles, Bresenham setup for lines.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_front (
  dtm_cmd_if.sink          cmd_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output dtm_pkg::job_t    push_job_o
);

  logic signed [dtm_pkg::BOX_W-1:0]   pad_s;
  logic signed [dtm_pkg::BOX_W-1:0]   sx_s, sy_s, w_s, h_s;
  logic signed [dtm_pkg::DELTA_W-1:0] diff_x, diff_y, abs_x, abs_y;
  dtm_pkg::kind_e                     kind;

  assign kind  = dtm_pkg::kind_e'(cmd_i.kind);
  assign pad_s = $signed({{(dtm_pkg::BOX_W-dtm_pkg::PAD_W){1'b0}}, cmd_i.padding});
  assign sx_s  = dtm_pkg::BOX_W'(cmd_i.start_x);
  assign sy_s  = dtm_pkg::BOX_W'(cmd_i.start_y);
  assign w_s   = dtm_pkg::BOX_W'(cmd_i.width);
  assign h_s   = dtm_pkg::BOX_W'(cmd_i.height);

  // line deltas
  assign diff_x = dtm_pkg::DELTA_W'(cmd_i.end_x) - dtm_pkg::DELTA_W'(cmd_i.start_x);
  assign diff_y = dtm_pkg::DELTA_W'(cmd_i.end_y) - dtm_pkg::DELTA_W'(cmd_i.start_y);
  assign abs_x  = diff_x[dtm_pkg::DELTA_W-1] ? -diff_x : diff_x;
  assign abs_y  = diff_y[dtm_pkg::DELTA_W-1] ? -diff_y : diff_y;

  // classify
  always_comb begin
    push_job_o      = '0;
    push_job_o.kind = kind;
    push_job_o.mark = 1'b1;
    case (kind)
      dtm_pkg::KIND_POINT: begin
        push_job_o.box.xa = sx_s - pad_s;
        push_job_o.box.ya = sy_s - pad_s;
        push_job_o.box.xb = sx_s + pad_s;
        push_job_o.box.yb = sy_s + pad_s;
      end
      dtm_pkg::KIND_RECT: begin
        push_job_o.mark   = (w_s > 0) && (h_s > 0);
        push_job_o.box.xa = sx_s - pad_s;
        push_job_o.box.ya = sy_s - pad_s;
        push_job_o.box.xb = sx_s + w_s - 14'sd1 + pad_s;
        push_job_o.box.yb = sy_s + h_s - 14'sd1 + pad_s;
      end
      dtm_pkg::KIND_LINE: begin
        push_job_o.line.x0    = cmd_i.start_x;
        push_job_o.line.y0    = cmd_i.start_y;
        push_job_o.line.x1    = cmd_i.end_x;
        push_job_o.line.y1    = cmd_i.end_y;
        push_job_o.line.dx    = abs_x;
        push_job_o.line.dy    = -abs_y;
        push_job_o.line.x_dec = !(cmd_i.start_x < cmd_i.end_x);
        push_job_o.line.y_dec = !(cmd_i.start_y < cmd_i.end_y);
        push_job_o.line.err   = dtm_pkg::ERR_W'(abs_x) - dtm_pkg::ERR_W'(abs_y);
        push_job_o.line.pad   = cmd_i.padding;
      end
      default: begin
        push_job_o.mark = 1'b0;
      end
    endcase
  end

  assign push_valid_o = cmd_i.valid;
  assign cmd_i.ready  = push_ready_i;

endmodule

`default_nettype wire

// File: sv/dtm_queue.sv
// ----------------------------------------------------------------------------
// Dirty tile mask marker job queue
// Short FIFO that decouples command intake from tile marking.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dtm_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dtm_pkg::job_t pop_job_o
);

  localparam logic [dtm_pkg::QPTR_W:0]   Full    = (dtm_pkg::QPTR_W+1)'(dtm_pkg::QUEUE_DEPTH);
  localparam logic [dtm_pkg::QPTR_W-1:0] LastPtr = dtm_pkg::QPTR_W'(dtm_pkg::QUEUE_DEPTH - 1);

  dtm_pkg::job_t               slots_q [dtm_pkg::QUEUE_DEPTH];
  logic [dtm_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dtm_pkg::QPTR_W:0]    count_q, count_d;
  logic                        push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = slots_q[rd_ptr_q];

  // pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // job slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/dtm_back.sv
// ----------------------------------------------------------------------------
// Dirty tile mask marker back end
// Holds the tile mask, marks boxes, walks lines one pixel a cycle (the last pixel waits
// until the mask output is free) and registers each resulting mask beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_back #(
  parameter int DISPLAY_WIDTH  = 240,
  parameter int DISPLAY_HEIGHT = 240,
  parameter int TILE_SIZE      = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  dtm_pkg::job_t pop_job_i,
  dtm_mask_if.source    mask_o
);

  localparam int TileCols = (DISPLAY_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam logic signed [dtm_pkg::BOX_W-1:0] XMax = dtm_pkg::BOX_W'(DISPLAY_WIDTH - 1);
  localparam logic signed [dtm_pkg::BOX_W-1:0] YMax = dtm_pkg::BOX_W'(DISPLAY_HEIGHT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LINE = 1'b1;

  logic                                 state_q, state_d;
  logic [dtm_pkg::MASK_BITS-1:0]        mask_q, mask_d;
  logic                                 out_valid_q, out_valid_d;
  logic [dtm_pkg::MASK_BITS-1:0]        out_mask_q, out_mask_d;
  dtm_pkg::line_t                       walk_q, walk_d;

  logic                                 out_free, at_end;
  dtm_pkg::box_t                        pix_box, sel_box;
  logic signed [dtm_pkg::BOX_W-1:0]     xa_c, ya_c, xb_c, yb_c, pad_s;
  logic [dtm_pkg::MASK_BITS-1:0]        hits;
  logic signed [dtm_pkg::ERR_W:0]       e2, dx_w, dy_w;
  logic                                 step_x, step_y;

  function automatic logic signed [dtm_pkg::BOX_W-1:0] clamp(
    input logic signed [dtm_pkg::BOX_W-1:0] v,
    input logic signed [dtm_pkg::BOX_W-1:0] hi
  );
    logic signed [dtm_pkg::BOX_W-1:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // padded box around the current line pixel
  assign pad_s      = $signed({{(dtm_pkg::BOX_W-dtm_pkg::PAD_W){1'b0}}, walk_q.pad});
  assign pix_box.xa = dtm_pkg::BOX_W'(walk_q.x0) - pad_s;
  assign pix_box.ya = dtm_pkg::BOX_W'(walk_q.y0) - pad_s;
  assign pix_box.xb = dtm_pkg::BOX_W'(walk_q.x0) + pad_s;
  assign pix_box.yb = dtm_pkg::BOX_W'(walk_q.y0) + pad_s;

  // one shared box marker
  assign sel_box = (state_q == ST_LINE) ? pix_box : pop_job_i.box;
  assign xa_c    = clamp(sel_box.xa, XMax);
  assign ya_c    = clamp(sel_box.ya, YMax);
  assign xb_c    = clamp(sel_box.xb, XMax);
  assign yb_c    = clamp(sel_box.yb, YMax);

  // a tile is hit when its pixel span overlaps the clamped box
  for (genvar gi = 0; gi < dtm_pkg::MASK_BITS; gi++) begin : g_tile
    localparam int Row = gi / TileCols;
    localparam int Col = gi % TileCols;
    localparam logic signed [dtm_pkg::BOX_W-1:0] XLo = dtm_pkg::BOX_W'(Col * TILE_SIZE);
    localparam logic signed [dtm_pkg::BOX_W-1:0] XHi = dtm_pkg::BOX_W'((Col + 1) * TILE_SIZE);
    localparam logic signed [dtm_pkg::BOX_W-1:0] YLo = dtm_pkg::BOX_W'(Row * TILE_SIZE);
    localparam logic signed [dtm_pkg::BOX_W-1:0] YHi = dtm_pkg::BOX_W'((Row + 1) * TILE_SIZE);
    assign hits[gi] = (xa_c < XHi) && (xb_c >= XLo) && (ya_c < YHi) && (yb_c >= YLo);
  end

  // Bresenham step decision
  assign e2     = {walk_q.err, 1'b0};
  assign dx_w   = (dtm_pkg::ERR_W+1)'(walk_q.dx);
  assign dy_w   = (dtm_pkg::ERR_W+1)'(walk_q.dy);
  assign step_x = (e2 >= dy_w);
  assign step_y = (e2 <= dx_w);
  assign at_end = (walk_q.x0 == walk_q.x1) && (walk_q.y0 == walk_q.y1);

  assign out_free = !out_valid_q || mask_o.ready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !mask_o.ready;
    out_mask_d  = out_mask_q;
    walk_d      = walk_q;
    pop_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_ready_o = (pop_job_i.kind == dtm_pkg::KIND_LINE) || out_free;
        if (pop_valid_i && pop_ready_o) begin
          case (pop_job_i.kind)
            dtm_pkg::KIND_POINT, dtm_pkg::KIND_RECT: begin
              if (pop_job_i.mark) begin
                mask_d = mask_q | hits;
              end
              out_valid_d = 1'b1;
              out_mask_d  = mask_d;
            end
            dtm_pkg::KIND_LINE: begin
              walk_d  = pop_job_i.line;
              state_d = ST_LINE;
            end
            dtm_pkg::KIND_CLEAR: begin
              out_valid_d = 1'b1;
              out_mask_d  = mask_q;
              mask_d      = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LINE: begin
        if (!at_end) begin
          mask_d = mask_q | hits;
          if (step_x) begin
            walk_d.x0 = walk_q.x_dec ? walk_q.x0 - 12'sd1 : walk_q.x0 + 12'sd1;
          end
          if (step_y) begin
            walk_d.y0 = walk_q.y_dec ? walk_q.y0 - 12'sd1 : walk_q.y0 + 12'sd1;
          end
          walk_d.err = dtm_pkg::ERR_W'((dtm_pkg::ERR_W+1)'(walk_q.err)
                       + (step_x ? dy_w : '0) + (step_y ? dx_w : '0));
        end else if (out_free) begin
          mask_d      = mask_q | hits;
          out_valid_d = 1'b1;
          out_mask_d  = mask_d;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_mask_q <= out_mask_d;
    walk_q     <= walk_d;
  end

  assign mask_o.valid      = out_valid_q;
  assign mask_o.dirty_mask = out_mask_q;

endmodule

`default_nettype wire

// File: sv/dirty_tile_mask_marker.sv
// Point, rectangle and read-and-clear pass the job queue, then give a registered mask beat.
// A line is walked pixel by pixel in the back-end walker (one pixel per cycle).
// Throughput: one point/rectangle/clear per cycle unless mask_o stalls or a line is walked.
// A two-entry job queue lets commands be taken while a line is being walked.
// Reset (rst_ni low, asynchronous): mask cleared, queue emptied, no result pending.
// ----------------------------------------------------------------------------
// Dirty tile mask marker
// Tracks which screen tiles need a redraw from point, rectangle and line commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_tile_mask_marker #(
  parameter int DISPLAY_WIDTH  = 240,
  parameter int DISPLAY_HEIGHT = 240,
  parameter int TILE_SIZE      = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtm_cmd_if.sink    cmd_i,
  dtm_mask_if.source mask_o
);

  `include "dirty_tile_mask_marker_assert.svh"

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic          box_pop;
  dtm_pkg::job_t push_job, pop_job;

  dtm_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  dtm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  dtm_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .TILE_SIZE      (TILE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .mask_o      (mask_o)
  );

  // back end takes a non-line job this cycle
  assign box_pop = pop_valid && pop_ready && (pop_job.kind != dtm_pkg::KIND_LINE);

  // command intake only stalls on a full queue
  `DTM_ASSERT_NOW(a_stall_means_queued, !cmd_i.ready, pop_valid)
  // an accepted beat is in the queue on the next cycle
  `DTM_ASSERT_NEXT(a_accept_queued, cmd_i.valid && cmd_i.ready, pop_valid)
  // non-line jobs produce a mask beat right away
  `DTM_ASSERT_NEXT(a_box_result, box_pop, mask_o.valid)

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dirty tile mask marker testbench
// Drives point, rectangle, line and read-and-clear commands into the marker,
// keeps a shadow copy of the tile mask, and checks every returned mask beat
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

  localparam int DISPLAY_WIDTH  = 240;
  localparam int DISPLAY_HEIGHT = 240;
  localparam int TILE_SIZE      = 40;
  localparam int TILE_COLS      = (DISPLAY_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_REPORTS    = 40;

  typedef logic signed [dtm_pkg::COORD_W-1:0] coord_t;
  typedef logic [dtm_pkg::MASK_BITS-1:0] mask_t;

  typedef struct {
    dtm_pkg::kind_e           kind;
    coord_t                   start_x;
    coord_t                   start_y;
    coord_t                   end_x;
    coord_t                   end_y;
    coord_t                   width;
    coord_t                   height;
    logic [dtm_pkg::PAD_W-1:0] padding;
  } tile_cmd_t;

  logic clk_i;
  logic rst_ni;

  dtm_cmd_if  cmd_bus ();
  dtm_mask_if mask_bus ();

  dirty_tile_mask_marker #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .TILE_SIZE      (TILE_SIZE)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .mask_o (mask_bus)
  );

  // Shadow state and bookkeeping
  mask_t tiles_shadow;
  mask_t mask_expected[$];
  int    mismatch_count;
  int    beats_checked;
  int    kind_count[4];
  int    burst_left;
  bit    idle_off;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run of this stimulus
  initial begin
    #2_000_000;
    $display("timeout with %0d mask beats still outstanding", mask_expected.size());
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Tile mask predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp_px(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void mark_tile_box(input int xa, input int ya, input int xb, input int yb);
    int c0, r0, c1, r1, r, c, idx;
    c0 = clamp_px(xa, DISPLAY_WIDTH - 1) / TILE_SIZE;
    r0 = clamp_px(ya, DISPLAY_HEIGHT - 1) / TILE_SIZE;
    c1 = clamp_px(xb, DISPLAY_WIDTH - 1) / TILE_SIZE;
    r1 = clamp_px(yb, DISPLAY_HEIGHT - 1) / TILE_SIZE;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        idx = r * TILE_COLS + c;
        // tiles past the mask width are dropped
        if (idx >= 0 && idx < dtm_pkg::MASK_BITS) tiles_shadow[idx] = 1'b1;
      end
    end
  endfunction

  function automatic void mark_pixel(input int x, input int y, input int pad);
    mark_tile_box(x - pad, y - pad, x + pad, y + pad);
  endfunction

  // Bresenham walk, both ends included
  function automatic void walk_line(input int x0, input int y0, input int x1, input int y1,
                                    input int pad);
    int dx, dy, step_x, step_y, err, e2;
    dx     = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy     = -((y1 > y0) ? y1 - y0 : y0 - y1);
    step_x = (x0 < x1) ? 1 : -1;
    step_y = (y0 < y1) ? 1 : -1;
    err    = dx + dy;
    forever begin
      mark_pixel(x0, y0, pad);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += step_x;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += step_y;
      end
    end
  endfunction

  function automatic mask_t predict_mask(input tile_cmd_t c);
    int    x, y, w, h, p;
    mask_t snap;
    x = int'(c.start_x);
    y = int'(c.start_y);
    w = int'(c.width);
    h = int'(c.height);
    p = int'(c.padding);
    case (c.kind)
      dtm_pkg::KIND_POINT: mark_pixel(x, y, p);
      dtm_pkg::KIND_RECT: begin
        // empty rectangles mark nothing
        if (w > 0 && h > 0) mark_tile_box(x - p, y - p, x + w - 1 + p, y + h - 1 + p);
      end
      dtm_pkg::KIND_LINE: walk_line(x, y, int'(c.end_x), int'(c.end_y), p);
      default: begin
        snap = tiles_shadow;
        tiles_shadow = '0;
        return snap;
      end
    endcase
    return tiles_shadow;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  function automatic coord_t rand12();
    return coord_t'($urandom);
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 367)) - 64;
  endfunction

  function automatic tile_cmd_t build_cmd(input dtm_pkg::kind_e k, input coord_t sx,
                                          input coord_t sy, input coord_t ex,
                                          input coord_t ey, input coord_t w,
                                          input coord_t h, input int pad);
    tile_cmd_t c;
    c.kind    = k;
    c.start_x = sx;
    c.start_y = sy;
    c.end_x   = ex;
    c.end_y   = ey;
    c.width   = w;
    c.height  = h;
    c.padding = pad[dtm_pkg::PAD_W-1:0];
    return c;
  endfunction

  task automatic drive_fields(input tile_cmd_t c);
    cmd_bus.kind    <= c.kind;
    cmd_bus.start_x <= c.start_x;
    cmd_bus.start_y <= c.start_y;
    cmd_bus.end_x   <= c.end_x;
    cmd_bus.end_y   <= c.end_y;
    cmd_bus.width   <= c.width;
    cmd_bus.height  <= c.height;
    cmd_bus.padding <= c.padding;
  endtask

  // One command beat; entered and left on a rising edge, valid left high
  task automatic send_cmd(input tile_cmd_t c);
    int gap;
    tile_cmd_t junk;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (idle_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        // idle gap with garbage on the payload
        junk = build_cmd(dtm_pkg::kind_e'($urandom_range(0, 3)), rand12(), rand12(),
                         rand12(), rand12(), rand12(), rand12(), $urandom_range(0, 255));
        cmd_bus.valid <= 1'b0;
        drive_fields(junk);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_bus.valid <= 1'b1;
    drive_fields(c);
    do @(posedge clk_i); while (!cmd_bus.ready);
    mask_expected.push_back(predict_mask(c));
    kind_count[c.kind]++;
  endtask

  task automatic send_point(input int x, input int y, input int pad);
    send_cmd(build_cmd(dtm_pkg::KIND_POINT, coord_t'(x), coord_t'(y), rand12(), rand12(),
                       rand12(), rand12(), pad));
  endtask

  task automatic send_rect(input int x, input int y, input int w, input int h, input int pad);
    send_cmd(build_cmd(dtm_pkg::KIND_RECT, coord_t'(x), coord_t'(y), rand12(), rand12(),
                       coord_t'(w), coord_t'(h), pad));
  endtask

  task automatic send_line(input int x0, input int y0, input int x1, input int y1,
                           input int pad);
    send_cmd(build_cmd(dtm_pkg::KIND_LINE, coord_t'(x0), coord_t'(y0), coord_t'(x1),
                       coord_t'(y1), rand12(), rand12(), pad));
  endtask

  task automatic send_clear();
    send_cmd(build_cmd(dtm_pkg::KIND_CLEAR, rand12(), rand12(), rand12(), rand12(),
                       rand12(), rand12(), $urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Mask side: stall pattern and in-order check
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] stall_pat;
    int          phase;
    mask_t       got;
    mask_t       want;
    stall_pat = '1;
    phase     = 0;
    mask_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (mask_bus.valid && mask_bus.ready) begin
          got = mask_bus.dirty_mask;
          if (mask_expected.size() == 0) begin
            report_mismatch($sformatf("mask beat %h with no command outstanding", got));
          end else begin
            want = mask_expected.pop_front();
            beats_checked++;
            if (got !== want)
              report_mismatch($sformatf("dirty_mask got %h want %h", got, want));
          end
        end
        // pick a new stall pattern each time the phase counter wraps
        phase++;
        if (phase == 48) begin
          phase = 0;
          case ($urandom_range(0, 3))
            0:       stall_pat = '1;
            1:       stall_pat = 16'(1) << $urandom_range(0, 15);
            default: stall_pat = 16'($urandom) | 16'h0001;
          endcase
        end
        mask_bus.ready <= idle_off ? 1'b1 : stall_pat[phase % 16];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_point_marks();
    send_point(0, 0, 0);
    send_point(DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1, 0);
    send_point(-2048, -2048, 0);        // far off screen, clamps to the corner tile
    send_point(2047, 2047, 255);
    send_clear();
    send_point(TILE_SIZE, TILE_SIZE - 1, 0);  // tile boundary
    send_point(120, 120, 255);          // covers every tile
    send_clear();
  endtask

  task automatic test_rect_marks();
    send_rect(50, 50, 0, 20, 3);        // empty: zero width
    send_rect(50, 50, 20, -5, 3);       // empty: negative height
    send_rect(10, 10, -2048, 2047, 0);  // empty: most negative width
    send_rect(300, 300, 10, 10, 0);     // wholly off screen
    send_rect(-2048, -2048, 2047, 2047, 255);
    send_clear();
  endtask

  task automatic test_line_walks();
    send_line(100, 100, 100, 100, 0);   // single pixel
    send_line(-30, 5, 260, 5, 0);       // horizontal through the top row
    send_line(200, 239, 200, 0, 2);     // vertical, walking up
    send_line(0, 239, 239, 0, 0);       // anti-diagonal
    send_clear();
    send_line(-2048, -2048, 2047, 2047, 0);
    send_line(2047, -2048, -2048, -600, 255);
  endtask

  task automatic test_read_and_clear();
    send_clear();
    send_clear();                       // nothing in between: empty mask
  endtask

  // No idling on either side, commands back to back
  task automatic test_back_to_back();
    int i;
    idle_off   = 1'b1;
    burst_left = 0;
    for (i = 0; i < 40; i++) begin
      case ($urandom_range(0, 3))
        0: send_point(near_coord(), near_coord(), $urandom_range(0, 8));
        1: send_rect(near_coord(), near_coord(), $urandom_range(0, 60),
                     $urandom_range(0, 60), $urandom_range(0, 8));
        2: send_line(near_coord(), 20, near_coord() % 8 + 20, 24, 0);
        default: send_clear();
      endcase
    end
    idle_off = 1'b0;
  endtask

  task automatic test_random_mix(input int n_items);
    int i, sel, pad;
    int x, y, w, h;
    for (i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      pad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      x   = ($urandom_range(0, 4) == 0) ? int'(rand12()) : near_coord();
      y   = ($urandom_range(0, 4) == 0) ? int'(rand12()) : near_coord();
      if (sel < 28) begin
        send_point(x, y, pad);
      end else if (sel < 52) begin
        case ($urandom_range(0, 9))
          0:       w = int'(rand12());
          1:       w = int'($urandom_range(0, 3)) - 3;
          default: w = $urandom_range(1, 130);
        endcase
        case ($urandom_range(0, 9))
          0:       h = int'(rand12());
          1:       h = int'($urandom_range(0, 3)) - 3;
          default: h = $urandom_range(1, 130);
        endcase
        send_rect(x, y, w, h, pad);
      end else if (sel < 82) begin
        // long full-range lines are kept rare, they walk thousands of pixels
        if ($urandom_range(0, 99) < 3)
          send_line(int'(rand12()), int'(rand12()), int'(rand12()), int'(rand12()), pad);
        else
          send_line(near_coord(), near_coord(), near_coord(), near_coord(), pad);
      end else begin
        send_clear();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tiles_shadow   = '0;
    mismatch_count = 0;
    beats_checked  = 0;
    kind_count     = '{default: 0};
    burst_left     = 0;
    idle_off       = 1'b0;
    rst_ni         = 1'b0;
    cmd_bus.valid   <= 1'b0;
    cmd_bus.kind    <= dtm_pkg::KIND_POINT;
    cmd_bus.start_x <= '0;
    cmd_bus.start_y <= '0;
    cmd_bus.end_x   <= '0;
    cmd_bus.end_y   <= '0;
    cmd_bus.width   <= '0;
    cmd_bus.height  <= '0;
    cmd_bus.padding <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_point_marks();
    test_rect_marks();
    test_line_walks();
    test_read_and_clear();
    test_back_to_back();
    test_random_mix(390);
    cmd_bus.valid <= 1'b0;

    // drain outstanding beats, then watch for strays
    while (mask_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d points, %0d rectangles, %0d lines, %0d read-and-clears",
             kind_count[dtm_pkg::KIND_POINT], kind_count[dtm_pkg::KIND_RECT],
             kind_count[dtm_pkg::KIND_LINE], kind_count[dtm_pkg::KIND_CLEAR]);
    $display("checked %0d mask beats, %0d mismatches", beats_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: dirty_tile_mask_marker.f
+incdir+sv
sv/dtm_pkg.sv
sv/dtm_if.sv
sv/dtm_front.sv
sv/dtm_queue.sv
sv/dtm_back.sv
sv/dirty_tile_mask_marker.sv
tb/tb.sv
